@@ rtl/slt_pkg.sv @@
// Shared types, codes and character constants for the small language tokenizer.
package slt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUMBER  = 3'd1,
        MODE_KEYWORD = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_DISCARD = 3'd4
    } mode_t;

    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_PRINT  = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_PLUS   = 3'd3;
    localparam logic [2:0] KIND_LPAREN = 3'd4;
    localparam logic [2:0] KIND_RPAREN = 3'd5;
    localparam logic [2:0] KIND_SEMI   = 3'd6;
    localparam logic [2:0] KIND_EOF    = 3'd7;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN      = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_A       = 8'h61;

    localparam logic [2:0] KW_LEN = 3'd6;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_value;
        logic       has_char;
        logic       tok_start;
        logic       tok_end;
        logic [1:0] err;
        logic       last;
    } result_t;

    // Results made by one accepted source byte, in output order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h61;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h64;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h6B;
            3'd5:    c = 8'h61;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] ch,
                                            input logic has, input logic st,
                                            input logic en, input logic [1:0] err);
        result_t r;
        r.kind       = kind;
        r.char_value = has ? ch : 8'h00;
        r.has_char   = has;
        r.tok_start  = st;
        r.tok_end    = en;
        r.err        = err;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/slt_front.sv @@
// Front end: accepts source bytes, runs the scanner state and forms the results.
module slt_front
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] source_byte,
    input  logic       queue_full,
    output push_t      push
);

    mode_t      mode_reg, mode_next;
    logic       quote_single_reg, quote_single_next;
    logic [2:0] kw_reg, kw_next;
    logic       has_chars_reg, has_chars_next;

    logic       accept;
    logic       is_digit;
    logic       is_space;
    logic [7:0] close_quote;

    logic       idle_emit;
    result_t    idle_res;
    mode_t      idle_mode;
    logic       idle_quote;
    logic [2:0] idle_kw;
    logic       idle_has;

    result_t    first, second;
    logic [1:0] cnt;

    assign accept      = in_valid && !queue_full;
    assign in_stall    = queue_full;
    assign is_digit    = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);
    assign is_space    = ((source_byte >= CH_TAB) && (source_byte <= CH_CR))
                         || (source_byte == CH_SPACE);
    assign close_quote = quote_single_reg ? CH_SQUOTE : CH_DQUOTE;

    // Handling of a byte seen with no token open; also used after a number ends.
    always_comb
    begin
        idle_emit  = 1'b0;
        idle_res   = '0;
        idle_mode  = MODE_IDLE;
        idle_quote = quote_single_reg;
        idle_kw    = kw_reg;
        idle_has   = has_chars_reg;
        if (source_byte == CH_NUL)
        begin
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end
        else if (is_space)
        begin
            idle_emit = 1'b0;
        end
        else if (is_digit)
        begin
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_NUMBER, source_byte, 1'b1, 1'b1, 1'b0, ERR_NONE);
            idle_mode = MODE_NUMBER;
        end
        else if (source_byte == CH_A)
        begin
            idle_mode = MODE_KEYWORD;
            idle_kw   = 3'd1;
        end
        else if ((source_byte == CH_DQUOTE) || (source_byte == CH_SQUOTE))
        begin
            idle_mode  = MODE_STRING;
            idle_quote = (source_byte == CH_SQUOTE);
            idle_has   = 1'b0;
        end
        else if (source_byte == CH_PLUS)
        begin
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_PLUS, CH_NUL, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end
        else if (source_byte == CH_LPAREN)
        begin
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_LPAREN, CH_NUL, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end
        else if (source_byte == CH_RPAREN)
        begin
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_RPAREN, CH_NUL, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end
        else if (source_byte == CH_SEMI)
        begin
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_SEMI, CH_NUL, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end
        else
        begin
            // Unknown character; the byte is nonzero here, so discard follows.
            idle_emit = 1'b1;
            idle_res  = make_result(KIND_NUMBER, CH_NUL, 1'b0, 1'b0, 1'b0, ERR_UNKNOWN);
            idle_mode = MODE_DISCARD;
            idle_kw   = 3'd0;
            idle_has  = 1'b0;
        end
    end

    always_comb
    begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        kw_next           = kw_reg;
        has_chars_next    = has_chars_reg;
        first             = '0;
        second            = '0;
        cnt               = 2'd0;
        unique case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    first = make_result(KIND_NUMBER, source_byte, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    cnt   = 2'd1;
                end
                else
                begin
                    // The number closes and the byte is then scanned as in idle.
                    first             = make_result(KIND_NUMBER, CH_NUL, 1'b0, 1'b0, 1'b1,
                                                    ERR_NONE);
                    second            = idle_res;
                    cnt               = idle_emit ? 2'd2 : 2'd1;
                    mode_next         = idle_mode;
                    quote_single_next = idle_quote;
                    kw_next           = idle_kw;
                    has_chars_next    = idle_has;
                end
            end
            MODE_KEYWORD:
            begin
                if ((kw_reg < KW_LEN) && (source_byte == kw_char(kw_reg)))
                begin
                    if ((kw_reg + 3'd1) == KW_LEN)
                    begin
                        first     = make_result(KIND_PRINT, CH_NUL, 1'b0, 1'b1, 1'b1,
                                                ERR_NONE);
                        cnt       = 2'd1;
                        kw_next   = 3'd0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        kw_next = kw_reg + 3'd1;
                    end
                end
                else
                begin
                    first          = make_result(KIND_NUMBER, CH_NUL, 1'b0, 1'b0, 1'b0,
                                                 ERR_UNKNOWN);
                    cnt            = 2'd1;
                    mode_next      = (source_byte == CH_NUL) ? MODE_IDLE : MODE_DISCARD;
                    kw_next        = 3'd0;
                    has_chars_next = 1'b0;
                end
            end
            MODE_STRING:
            begin
                if (source_byte == CH_NUL)
                begin
                    first          = make_result(KIND_NUMBER, CH_NUL, 1'b0, 1'b0, 1'b0,
                                                 ERR_UNTERMINATED);
                    cnt            = 2'd1;
                    mode_next      = MODE_IDLE;
                    kw_next        = 3'd0;
                    has_chars_next = 1'b0;
                end
                else if (source_byte == close_quote)
                begin
                    first          = make_result(KIND_STRING, CH_NUL, 1'b0, !has_chars_reg,
                                                 1'b1, ERR_NONE);
                    cnt            = 2'd1;
                    has_chars_next = 1'b0;
                    mode_next      = MODE_IDLE;
                end
                else
                begin
                    first          = make_result(KIND_STRING, source_byte, 1'b1,
                                                 !has_chars_reg, 1'b0, ERR_NONE);
                    cnt            = 2'd1;
                    has_chars_next = 1'b1;
                end
            end
            MODE_DISCARD:
            begin
                if (source_byte == CH_NUL)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                first             = idle_res;
                cnt               = idle_emit ? 2'd1 : 2'd0;
                mode_next         = idle_mode;
                quote_single_next = idle_quote;
                kw_next           = idle_kw;
                has_chars_next    = idle_has;
            end
        endcase
        if (cnt == 2'd2)
        begin
            second.last = 1'b1;
        end
        else
        begin
            first.last = 1'b1;
        end
    end

    assign push.count  = accept ? cnt : 2'd0;
    assign push.first  = first;
    assign push.second = second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            kw_reg           <= 3'd0;
            has_chars_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            kw_reg           <= kw_next;
            has_chars_reg    <= has_chars_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_kw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_KEYWORD) |-> ((kw_reg != 3'd0) && (kw_reg < KW_LEN)))
        else $error("keyword progress out of range while matching");

    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == MODE_DISCARD)) |-> (push.count == 2'd0))
        else $error("result produced while discarding");

    a_nul_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (source_byte == CH_NUL)) |=> (mode_reg == MODE_IDLE))
        else $error("scanner not idle after end of source");
`endif

endmodule

@@ rtl/slt_queue.sv @@
// Result queue between the scanner and the output stage; takes up to two words a cycle.
module slt_queue
    import slt_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    full,
    input  logic    pop,
    output logic    nonempty,
    output result_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_MARK = CNT_W'(DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(DEPTH);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop_ok;

    assign nonempty = (count_reg != '0);
    // Room for two words must remain, since one byte may give two results.
    assign full     = (count_reg > FULL_MARK);
    assign pop_ok   = pop && nonempty;
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop_ok);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop_ok);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (count_reg <= FULL_MARK))
        else $error("two words written without room");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == (rd_ptr_reg + PTR_W'(count_reg)))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/slt_back.sv @@
// Output stage: moves one result word a cycle from the queue into the output register while out_stall is low.
module slt_back
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       nonempty,
    input  result_t    head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] token_kind,
    output logic [7:0] char_value,
    output logic       has_char,
    output logic       token_start,
    output logic       token_end,
    output logic [1:0] error_code,
    output logic       last
);

    logic    valid_reg;
    result_t data_reg;
    logic    take;

    // The register loads whenever it is empty or its word leaves this cycle.
    assign take = !valid_reg || !out_stall;
    assign pop  = take && nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= nonempty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head;
        end
    end

    assign out_valid   = valid_reg;
    assign token_kind  = data_reg.kind;
    assign char_value  = data_reg.char_value;
    assign has_char    = data_reg.has_char;
    assign token_start = data_reg.tok_start;
    assign token_end   = data_reg.tok_end;
    assign error_code  = data_reg.err;
    assign last        = data_reg.last;

endmodule

@@ rtl/small_language_tokenizer_core.sv @@
// Tokenizer core: takes one source byte a cycle and gives one result word a cycle.
// A source byte is taken in every cycle while in_stall is low. The scanner turns it into
// zero, one or two result words at once and writes them into a result queue of
// QUEUE_DEPTH words (a power of two, 4 or more); an output register sends one word per
// cycle while out_stall is low. Each result word is written into the queue at the edge
// that accepts its byte and then loaded into the output register. Bytes that give at
// most one word flow at one byte per cycle while out_stall is low. Only a byte that
// closes a number and is itself a token or an unknown character gives two words, and
// the byte after it gives at most one. A stream such as digits alternating with plus
// signs therefore carries three words per two bytes and runs at the pace of the output
// register. in_stall rises while the queue holds more than QUEUE_DEPTH minus two words.
module small_language_tokenizer_core
    import slt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] source_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] token_kind,
    output logic [7:0] char_value,
    output logic       has_char,
    output logic       token_start,
    output logic       token_end,
    output logic [1:0] error_code,
    output logic       last
);

    push_t   push;
    logic    queue_full;
    logic    queue_nonempty;
    logic    queue_pop;
    result_t queue_head;

    slt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .queue_full  (queue_full),
        .push        (push)
    );

    slt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (queue_full),
        .pop      (queue_pop),
        .nonempty (queue_nonempty),
        .head     (queue_head)
    );

    slt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .nonempty    (queue_nonempty),
        .head        (queue_head),
        .pop         (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .char_value  (char_value),
        .has_char    (has_char),
        .token_start (token_start),
        .token_end   (token_end),
        .error_code  (error_code),
        .last        (last)
    );

endmodule

@@ sim/small_language_tokenizer_core_test.sv @@
// Self-checking testbench for the small language tokenizer core with random idling on both sides.
module small_language_tokenizer_core_test;
    import slt_pkg::*;

    localparam int BYTE_TARGET  = 750;
    localparam int MAX_WAIT     = 12;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_LIMIT  = 50;

    class token_scoreboard;
        result_t expected_tokens[$];
        result_t made[$];
        mode_t   mode;
        bit      single_quote;
        int      kw_count;
        bit      str_nonempty;
        int      errors;
        string   keyword;

        function new();
            mode         = MODE_IDLE;
            single_quote = 1'b0;
            kw_count     = 0;
            str_nonempty = 1'b0;
            errors       = 0;
            keyword      = "andika";
        endfunction

        function void add(logic [2:0] kind, logic [7:0] ch, bit has, bit st, bit en,
                          logic [1:0] err);
            result_t r;
            r.kind       = kind;
            r.char_value = has ? ch : 8'h00;
            r.has_char   = has;
            r.tok_start  = st;
            r.tok_end    = en;
            r.err        = err;
            r.last       = 1'b0;
            made.push_back(r);
        endfunction

        function void flag_error(logic [7:0] b, logic [1:0] code);
            add(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b0, code);
            mode         = (b == CH_NUL) ? MODE_IDLE : MODE_DISCARD;
            kw_count     = 0;
            str_nonempty = 1'b0;
        endfunction

        function void from_idle(logic [7:0] b);
            mode = MODE_IDLE;
            if (b == CH_NUL)
                add(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            else if ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE)
            begin
                // Whitespace gives nothing.
            end
            else if (b >= CH_ZERO && b <= CH_NINE)
            begin
                add(KIND_NUMBER, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
                mode = MODE_NUMBER;
            end
            else if (b == CH_A)
            begin
                mode     = MODE_KEYWORD;
                kw_count = 1;
            end
            else if (b == CH_DQUOTE || b == CH_SQUOTE)
            begin
                mode         = MODE_STRING;
                single_quote = (b == CH_SQUOTE);
                str_nonempty = 1'b0;
            end
            else if (b == CH_PLUS)
                add(KIND_PLUS, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            else if (b == CH_LPAREN)
                add(KIND_LPAREN, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            else if (b == CH_RPAREN)
                add(KIND_RPAREN, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            else if (b == CH_SEMI)
                add(KIND_SEMI, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            else
                flag_error(b, ERR_UNKNOWN);
        endfunction

        // Works out the words one accepted source byte must produce.
        function void note_byte(logic [7:0] b);
            logic [7:0] q;
            result_t    r;
            made.delete();
            case (mode)
                MODE_NUMBER:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                        add(KIND_NUMBER, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    else
                    begin
                        // The closing byte ends the number and is then scanned afresh.
                        add(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        from_idle(b);
                    end
                end
                MODE_KEYWORD:
                begin
                    if (kw_count < KW_LEN && b == keyword[kw_count])
                    begin
                        kw_count++;
                        if (kw_count == KW_LEN)
                        begin
                            add(KIND_PRINT, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                            kw_count = 0;
                            mode     = MODE_IDLE;
                        end
                    end
                    else
                        flag_error(b, ERR_UNKNOWN);
                end
                MODE_STRING:
                begin
                    q = single_quote ? CH_SQUOTE : CH_DQUOTE;
                    if (b == CH_NUL)
                        flag_error(b, ERR_UNTERMINATED);
                    else if (b == q)
                    begin
                        add(KIND_STRING, 8'h00, 1'b0, !str_nonempty, 1'b1, ERR_NONE);
                        str_nonempty = 1'b0;
                        mode         = MODE_IDLE;
                    end
                    else
                    begin
                        add(KIND_STRING, b, 1'b1, !str_nonempty, 1'b0, ERR_NONE);
                        str_nonempty = 1'b1;
                    end
                end
                MODE_DISCARD:
                begin
                    if (b == CH_NUL)
                        mode = MODE_IDLE;
                end
                default:
                    from_idle(b);
            endcase
            if (made.size() > 0)
            begin
                r = made[made.size() - 1];
                r.last = 1'b1;
                made[made.size() - 1] = r;
            end
            foreach (made[i])
                expected_tokens.push_back(made[i]);
        endfunction

        function void report(string field, int want, int got);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: unexpected word, expected none actual %h", $time, got);
                return;
            end
            want = expected_tokens.pop_front();
            if (want.kind != got.kind)
                report("token_kind", want.kind, got.kind);
            if (want.char_value != got.char_value)
                report("char_value", want.char_value, got.char_value);
            if (want.has_char != got.has_char)
                report("has_char", want.has_char, got.has_char);
            if (want.tok_start != got.tok_start)
                report("token_start", want.tok_start, got.tok_start);
            if (want.tok_end != got.tok_end)
                report("token_end", want.tok_end, got.tok_end);
            if (want.err != got.err)
                report("error_code", want.err, got.err);
            if (want.last != got.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] source_byte;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] token_kind;
    logic [7:0] char_value;
    logic       has_char;
    logic       token_start;
    logic       token_end;
    logic [1:0] error_code;
    logic       last;

    token_scoreboard board = new();
    int  bytes_sent  = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;

    small_language_tokenizer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .char_value  (char_value),
        .has_char    (has_char),
        .token_start (token_start),
        .token_end   (token_end),
        .error_code  (error_code),
        .last        (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        source_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        board.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] space_byte();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : CH_TAB + pick[7:0];
    endfunction

    task automatic send_noise();
        int         sub;
        int         len;
        logic [7:0] q;
        sub = $urandom_range(0, 3);
        case (sub)
            0:
                send_byte(8'($urandom_range(0, 255)));
            1:
            begin
                // A keyword prefix of one to five letters followed by a random byte.
                len = $urandom_range(1, 5);
                send_text(board.keyword.substr(0, len - 1));
                send_byte(8'($urandom_range(0, 255)));
            end
            2:
            begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                send_byte(q);
                repeat ($urandom_range(0, 3)) send_byte(CH_A);
                send_byte(CH_NUL);
            end
            default:
            begin
                send_byte(8'h80 + 8'($urandom_range(0, 127)));
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)));
            end
        endcase
    endtask

    task automatic send_string();
        logic [7:0] q;
        logic [7:0] c;
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_byte(q);
        repeat ($urandom_range(0, 4))
        begin
            c = 8'($urandom_range(1, 255));
            if (c == q)
                c = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
            send_byte(c);
        end
        send_byte(q);
    endtask

    // One source text: mostly well-formed tokens, now and then a broken one.
    task automatic run_program();
        int n_tok;
        int kind;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(3, 10)) send_byte(8'($urandom_range(1, 255)));
            send_byte(CH_NUL);
            return;
        end
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            repeat ($urandom_range(0, 2)) send_byte(space_byte());
            kind = $urandom_range(0, 16);
            case (kind)
                0, 1, 2, 3:
                    repeat ($urandom_range(1, 4))
                        send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                4, 5:
                    send_text(board.keyword);
                6, 7, 8:
                    send_string();
                9, 10:
                    send_byte(CH_PLUS);
                11:
                    send_byte(CH_LPAREN);
                12:
                    send_byte(CH_RPAREN);
                13, 14:
                    send_byte(CH_SEMI);
                default:
                    send_noise();
            endcase
        end
        send_byte(CH_NUL);
    endtask

    initial
    begin : word_sink
        result_t seen;
        int      w;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            w = draw_wait();
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            seen.kind       = token_kind;
            seen.char_value = char_value;
            seen.has_char   = has_char;
            seen.tok_start  = token_start;
            seen.tok_end    = token_end;
            seen.err        = error_code;
            seen.last       = last;
            board.check_word(seen);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        source_byte = 8'h00;
        out_stall   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts: number closed by end of text and by a token, keyword broken by
        // end of text, empty string, the other quote as text, print, brackets, a high
        // unknown byte followed by discarded bytes, an unterminated string, whitespace.
        send_text("9");
        send_byte(CH_NUL);
        send_text("12+");
        send_text("a");
        send_byte(CH_NUL);
        send_text("''");
        send_text("\"'\"");
        send_text("andika");
        send_text("();");
        send_byte(8'hFF);
        send_text("z");
        send_byte(CH_NUL);
        send_text("\"");
        send_byte(CH_NUL);
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(CH_SPACE);

        while (bytes_sent < BYTE_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            run_program();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (board.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/slt_pkg.sv
rtl/slt_front.sv
rtl/slt_queue.sv
rtl/slt_back.sv
rtl/small_language_tokenizer_core.sv
sim/small_language_tokenizer_core_test.sv
